// ===== rtl/y2i_pkg.sv =====
// Shared types and constants for the YUYV 4:2:2 to planar 4:2:0 converter.
// Used by every module in rtl/; depends on nothing.
`default_nettype none

package y2i_pkg;

  localparam int LINE_PAIRS_W = 11;
  localparam int FRAME_ROWS_W = 12;
  localparam int CFG_DATA_W   = 12;
  localparam int CFG_INDEX_W  = 1;
  localparam int OFF_W        = 22;
  localparam int PLANE_W      = 2;
  localparam int BYTE_W       = 8;
  localparam int QUEUE_DEPTH  = 4;

  localparam int MAX_LINE_PAIRS_DEF = 1024;
  localparam int MAX_ROWS_DEF       = 2048;

  localparam logic [LINE_PAIRS_W-1:0] LINE_PAIRS_RST = LINE_PAIRS_W'(320);
  localparam logic [FRAME_ROWS_W-1:0] FRAME_ROWS_RST = FRAME_ROWS_W'(480);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LINE_PAIRS = 1'b0,
    REG_FRAME_ROWS = 1'b1
  } reg_index_t;

  typedef enum logic [PLANE_W-1:0] {
    PLANE_Y = 2'd0,
    PLANE_U = 2'd1,
    PLANE_V = 2'd2
  } plane_t;

  // even row: Y0 Y1; odd row: Y0 Y1 U V
  typedef enum logic {
    KIND_EVEN = 1'b0,
    KIND_ODD  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic              done;
    logic [BYTE_W-1:0] y0;
    logic [BYTE_W-1:0] y1;
    logic [BYTE_W-1:0] u;
    logic [BYTE_W-1:0] v;
    logic [BYTE_W-1:0] su;
    logic [BYTE_W-1:0] sv;
    logic [OFF_W-1:0]  yoff;
    logic [OFF_W-1:0]  coff;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/y2i_front.sv =====
// Front end: column/row counters, macropixel classification, chroma line
// buffer and plane base offsets. Depends on y2i_pkg.
`default_nettype none

module y2i_front #(
  parameter int MAX_LINE_PAIRS = y2i_pkg::MAX_LINE_PAIRS_DEF,
  parameter int MAX_ROWS       = y2i_pkg::MAX_ROWS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [y2i_pkg::LINE_PAIRS_W-1:0]    line_pairs,
  input  logic [y2i_pkg::FRAME_ROWS_W-1:0]    frame_rows,
  input  logic                                px_valid,
  output logic                                px_stall,
  input  logic [y2i_pkg::BYTE_W-1:0]          luma_first,
  input  logic [y2i_pkg::BYTE_W-1:0]          chroma_blue,
  input  logic [y2i_pkg::BYTE_W-1:0]          luma_second,
  input  logic [y2i_pkg::BYTE_W-1:0]          chroma_red,
  input  logic                                q_full,
  output logic                                push,
  output y2i_pkg::entry_t                     entry
);

  localparam int COL_W   = ($clog2(MAX_LINE_PAIRS) > 1) ? $clog2(MAX_LINE_PAIRS) : 1;
  localparam int ROW_W   = ($clog2(MAX_ROWS) > 2) ? $clog2(MAX_ROWS) : 2;
  localparam int PAIRS_W = $clog2(MAX_LINE_PAIRS + 1);
  localparam int ROWS_W  = $clog2(MAX_ROWS + 1);
  localparam int PROD_W  = ROW_W + PAIRS_W;
  localparam int OFF_W   = y2i_pkg::OFF_W;
  localparam int BYTE_W  = y2i_pkg::BYTE_W;

  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic [PAIRS_W-1:0] pairs;
  logic [ROWS_W-1:0]  rows;
  logic               end_line;
  logic               end_frame;
  logic               odd;
  logic               emit;
  logic               done;
  logic               accept;
  logic [COL_W-1:0]   idx;
  logic [PROD_W-1:0]  prod;

  logic [2*BYTE_W-1:0] chroma_line [MAX_LINE_PAIRS];

  logic                s1_valid;
  logic [BYTE_W-1:0]   s1_y0;
  logic [BYTE_W-1:0]   s1_u;
  logic [BYTE_W-1:0]   s1_y1;
  logic [BYTE_W-1:0]   s1_v;
  logic [2*BYTE_W-1:0] s1_rd;
  logic [OFF_W-1:0]    s1_p;
  logic [COL_W-1:0]    s1_col;
  logic [PAIRS_W-1:0]  s1_pairs;
  logic                s1_odd;
  logic                s1_done;

  always_comb begin
    if (line_pairs == '0) begin
      pairs = PAIRS_W'(1);
    end else if (int'(line_pairs) > MAX_LINE_PAIRS) begin
      pairs = PAIRS_W'(MAX_LINE_PAIRS);
    end else begin
      pairs = PAIRS_W'(line_pairs);
    end
    if (int'(frame_rows) < 2) begin
      rows = ROWS_W'(2);
    end else if (int'(frame_rows) > MAX_ROWS) begin
      rows = ROWS_W'(MAX_ROWS);
    end else begin
      rows = ROWS_W'(frame_rows);
    end
  end

  assign end_line  = (int'(col) + 1) >= int'(pairs);
  assign end_frame = end_line && ((int'(row) + 1) >= int'(rows));
  assign odd       = row[0];
  assign emit      = odd || ((int'(row) + 1) < int'(rows));
  assign done      = end_line && ((int'(row) + 2) >= int'(rows));
  assign idx       = (int'(col) < MAX_LINE_PAIRS) ? col : COL_W'(MAX_LINE_PAIRS - 1);
  assign prod      = PROD_W'(row >> 1) * PROD_W'(pairs);

  assign px_stall = s1_valid && q_full;
  assign accept   = px_valid && !px_stall;
  assign push     = s1_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (end_frame) begin
        col <= '0;
        row <= '0;
      end else if (end_line) begin
        col <= '0;
        row <= row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept && emit) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  // line buffer: even rows write, odd rows read the same column
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rd <= chroma_line[idx];
      if (!odd && emit) begin
        chroma_line[idx] <= {chroma_red, chroma_blue};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_y0    <= luma_first;
      s1_u     <= chroma_blue;
      s1_y1    <= luma_second;
      s1_v     <= chroma_red;
      s1_p     <= OFF_W'(prod);
      s1_col   <= col;
      s1_pairs <= pairs;
      s1_odd   <= odd;
      s1_done  <= done;
    end
  end

  // luma: 4*P + 2*pairs (odd row) + 2*col; chroma: P + col; P = (row/2)*pairs
  always_comb begin
    entry.kind = s1_odd ? y2i_pkg::KIND_ODD : y2i_pkg::KIND_EVEN;
    entry.done = s1_odd && s1_done;
    entry.y0   = s1_y0;
    entry.y1   = s1_y1;
    entry.u    = s1_u;
    entry.v    = s1_v;
    entry.su   = s1_rd[BYTE_W-1:0];
    entry.sv   = s1_rd[2*BYTE_W-1:BYTE_W];
    entry.yoff = (s1_p << 2)
               + (s1_odd ? (OFF_W'(s1_pairs) << 1) : '0)
               + (OFF_W'(s1_col) << 1);
    entry.coff = s1_p + OFF_W'(s1_col);
  end

endmodule

`default_nettype wire

// ===== rtl/y2i_queue.sv =====
// Short FIFO of classified macropixels between front and back ends.
// Depends on y2i_pkg.
`default_nettype none

module y2i_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  y2i_pkg::entry_t wr_entry,
  output logic            full,
  input  logic            pop,
  output y2i_pkg::entry_t head,
  output logic            empty
);

  localparam int DEPTH = y2i_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  y2i_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (int'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (int'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/y2i_back.sv =====
// Back end: steps through the results of the queue head, one per cycle while not
// stalled or empty, chroma averaging and the registered result stage. Depends on y2i_pkg.
`default_nettype none

module y2i_back (
  input  logic                         clk,
  input  logic                         rst,
  input  y2i_pkg::entry_t              head,
  input  logic                         empty,
  output logic                         pop,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [y2i_pkg::PLANE_W-1:0]  plane,
  output logic [y2i_pkg::OFF_W-1:0]    offset,
  output logic [y2i_pkg::BYTE_W-1:0]   value,
  output logic                         last_of_run,
  output logic                         frame_done
);

  localparam int OFF_W  = y2i_pkg::OFF_W;
  localparam int BYTE_W = y2i_pkg::BYTE_W;

  logic [1:0]          step;
  logic [1:0]          last_step;
  logic                load;
  logic                is_last;
  logic [BYTE_W:0]     sum_u;
  logic [BYTE_W:0]     sum_v;
  y2i_pkg::plane_t     plane_next;
  logic [OFF_W-1:0]    offset_next;
  logic [BYTE_W-1:0]   value_next;

  assign last_step = (head.kind == y2i_pkg::KIND_ODD) ? 2'd3 : 2'd1;
  assign is_last   = (step == last_step);
  assign load      = !empty && (!res_valid || !res_stall);
  assign pop       = load && is_last;
  assign sum_u     = {1'b0, head.su} + {1'b0, head.u};
  assign sum_v     = {1'b0, head.sv} + {1'b0, head.v};

  always_comb begin
    unique case (step)
      2'd0: begin
        plane_next  = y2i_pkg::PLANE_Y;
        offset_next = head.yoff;
        value_next  = head.y0;
      end
      2'd1: begin
        plane_next  = y2i_pkg::PLANE_Y;
        offset_next = head.yoff + OFF_W'(1);
        value_next  = head.y1;
      end
      2'd2: begin
        plane_next  = y2i_pkg::PLANE_U;
        offset_next = head.coff;
        value_next  = sum_u[BYTE_W:1];
      end
      default: begin
        plane_next  = y2i_pkg::PLANE_V;
        offset_next = head.coff;
        value_next  = sum_v[BYTE_W:1];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (load) begin
        step      <= is_last ? 2'd0 : step + 2'd1;
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      plane       <= plane_next;
      offset      <= offset_next;
      value       <= value_next;
      last_of_run <= is_last;
      frame_done  <= is_last && head.done;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/yuyv422_to_yuv420_planar.sv =====
// Top level of the YUYV 4:2:2 to planar 4:2:0 converter: configuration
// registers, front end, queue and back end. Depends on y2i_pkg and y2i_*.
//
//   channel | signals                                      | flow
//   --------+----------------------------------------------+------------------
//   px      | px_valid/px_stall, luma_first..chroma_red    | macropixels in
//   res     | res_valid/res_stall, plane, offset, value,   | bytes out
//           | last_of_run, frame_done                      |
//   cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data     | register writes
//
// One result per cycle while the queue holds data and res is not stalled: an
// even-row macropixel gives Y0 and Y1, an odd-row Y0, Y1, U and V. The first
// result passes through the front stage, a queue slot and the output register.
// A stalled output fills the 4-entry queue and the front stage before px stalls.
// Synchronous reset clears counters, queue and valids; the line buffer is
// left uncleared, no clearing pass.
`default_nettype none

module yuyv422_to_yuv420_planar #(
  parameter int MAX_LINE_PAIRS = y2i_pkg::MAX_LINE_PAIRS_DEF,
  parameter int MAX_ROWS       = y2i_pkg::MAX_ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              px_valid,
  output logic                              px_stall,
  input  logic [y2i_pkg::BYTE_W-1:0]        luma_first,
  input  logic [y2i_pkg::BYTE_W-1:0]        chroma_blue,
  input  logic [y2i_pkg::BYTE_W-1:0]        luma_second,
  input  logic [y2i_pkg::BYTE_W-1:0]        chroma_red,
  output logic                              res_valid,
  input  logic                              res_stall,
  output logic [y2i_pkg::PLANE_W-1:0]       plane,
  output logic [y2i_pkg::OFF_W-1:0]         offset,
  output logic [y2i_pkg::BYTE_W-1:0]        value,
  output logic                              last_of_run,
  output logic                              frame_done,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [y2i_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [y2i_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [y2i_pkg::LINE_PAIRS_W-1:0] line_pairs;
  logic [y2i_pkg::FRAME_ROWS_W-1:0] frame_rows;
  logic                             push;
  logic                             q_full;
  logic                             q_empty;
  logic                             pop;
  y2i_pkg::entry_t                  wr_entry;
  y2i_pkg::entry_t                  head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_pairs <= y2i_pkg::LINE_PAIRS_RST;
      frame_rows <= y2i_pkg::FRAME_ROWS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (y2i_pkg::reg_index_t'(cfg_index))
        y2i_pkg::REG_LINE_PAIRS: line_pairs <= cfg_data[y2i_pkg::LINE_PAIRS_W-1:0];
        y2i_pkg::REG_FRAME_ROWS: frame_rows <= cfg_data[y2i_pkg::FRAME_ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  y2i_front #(
    .MAX_LINE_PAIRS(MAX_LINE_PAIRS),
    .MAX_ROWS      (MAX_ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .line_pairs (line_pairs),
    .frame_rows (frame_rows),
    .px_valid   (px_valid),
    .px_stall   (px_stall),
    .luma_first (luma_first),
    .chroma_blue(chroma_blue),
    .luma_second(luma_second),
    .chroma_red (chroma_red),
    .q_full     (q_full),
    .push       (push),
    .entry      (wr_entry)
  );

  y2i_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_entry(wr_entry),
    .full    (q_full),
    .pop     (pop),
    .head    (head),
    .empty   (q_empty)
  );

  y2i_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (q_empty),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .plane      (plane),
    .offset     (offset),
    .value      (value),
    .last_of_run(last_of_run),
    .frame_done (frame_done)
  );

endmodule

`default_nettype wire

// ===== rtl/y2i_checker.sv =====
// Port-level checks for yuyv422_to_yuv420_planar, attached by bind.
// Depends on y2i_pkg.
`default_nettype none

module y2i_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              px_stall,
  input logic                              res_valid,
  input logic                              res_stall,
  input logic [y2i_pkg::PLANE_W-1:0]       plane,
  input logic [y2i_pkg::OFF_W-1:0]         offset,
  input logic [y2i_pkg::BYTE_W-1:0]        value,
  input logic                              last_of_run,
  input logic                              frame_done
);

  localparam logic [y2i_pkg::PLANE_W-1:0] PLANE_W_U = y2i_pkg::PLANE_U;
  localparam logic [y2i_pkg::PLANE_W-1:0] PLANE_W_V = y2i_pkg::PLANE_V;

  // stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid &&
      $stable(plane) && $stable(offset) && $stable(value) &&
      $stable(last_of_run) && $stable(frame_done))
    else $error("result changed while stalled");

  // frame end only on the V byte closing a macropixel
  a_done_on_v: assert property (@(posedge clk) disable iff (rst)
    res_valid && frame_done |-> last_of_run &&
      plane == PLANE_W_V)
    else $error("frame_done outside final V result");

  // a U transfer is followed at once by the V byte at the same offset
  a_u_then_v: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_stall && plane == PLANE_W_U |=>
      res_valid && plane == PLANE_W_V && offset == $past(offset) && !$past(last_of_run))
    else $error("U result not followed by matching V");

  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !res_valid && !px_stall)
    else $error("valid or stall after reset");

endmodule

bind yuyv422_to_yuv420_planar y2i_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .px_stall   (px_stall),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .plane      (plane),
  .offset     (offset),
  .value      (value),
  .last_of_run(last_of_run),
  .frame_done (frame_done)
);

`default_nettype wire

// ===== verif/y2i_plane_checker.sv =====
`timescale 1ns / 1ps
// Output checker for yuyv422_to_yuv420_planar: follows the pixel, result and
// register channels, predicts every planar byte and compares it on transfer.
// Depends on y2i_pkg.

module y2i_plane_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            px_valid,
  input  logic                            px_stall,
  input  logic [y2i_pkg::BYTE_W-1:0]      luma_first,
  input  logic [y2i_pkg::BYTE_W-1:0]      chroma_blue,
  input  logic [y2i_pkg::BYTE_W-1:0]      luma_second,
  input  logic [y2i_pkg::BYTE_W-1:0]      chroma_red,
  input  logic                            res_valid,
  input  logic                            res_stall,
  input  logic [y2i_pkg::PLANE_W-1:0]     plane,
  input  logic [y2i_pkg::OFF_W-1:0]       offset,
  input  logic [y2i_pkg::BYTE_W-1:0]      value,
  input  logic                            last_of_run,
  input  logic                            frame_done,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [y2i_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [y2i_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int unsigned                     errors,
  output int unsigned                     pending
);

  localparam int BYTE_W    = y2i_pkg::BYTE_W;
  localparam int OFF_W     = y2i_pkg::OFF_W;
  localparam int MAX_PAIRS = y2i_pkg::MAX_LINE_PAIRS_DEF;
  localparam int MAX_ROWS  = y2i_pkg::MAX_ROWS_DEF;

  typedef struct {
    y2i_pkg::plane_t   plane;
    logic [OFF_W-1:0]  offset;
    logic [BYTE_W-1:0] value;
    logic              last;
    logic              done;
  } planar_byte_t;

  planar_byte_t                     planar_bytes_due[$];
  logic [y2i_pkg::LINE_PAIRS_W-1:0] line_pairs_reg;
  logic [y2i_pkg::FRAME_ROWS_W-1:0] frame_rows_reg;
  logic [9:0]                       column_at;
  logic [10:0]                      row_at;
  logic [2*BYTE_W-1:0]              chroma_store [MAX_PAIRS];
  int unsigned                      fault_count = 0;

  assign errors = fault_count;

  task automatic queue_byte(input y2i_pkg::plane_t p, input int unsigned off,
                            input logic [BYTE_W-1:0] val, input logic last,
                            input logic done);
    planar_byte_t b;
    b.plane  = p;
    b.offset = OFF_W'(off);
    b.value  = val;
    b.last   = last;
    b.done   = done;
    planar_bytes_due.insert(planar_bytes_due.size(), b);
  endtask

  task automatic convert_macropixel(input logic [BYTE_W-1:0] y0, u, y1, v);
    int unsigned pairs, rows, col, row, yoff, coff;
    logic        end_line, end_frame;
    logic [BYTE_W-1:0] su, sv;
    pairs = line_pairs_reg;
    if (pairs < 1) pairs = 1;
    if (pairs > MAX_PAIRS) pairs = MAX_PAIRS;
    rows = frame_rows_reg;
    if (rows < 2) rows = 2;
    if (rows > MAX_ROWS) rows = MAX_ROWS;
    col = column_at;
    row = row_at;
    end_line  = (col + 1 >= pairs);
    end_frame = end_line && (row + 1 >= rows);
    yoff = row * 2 * pairs + 2 * col;
    if (!row_at[0]) begin
      // last row of an odd-height frame is dropped
      if (row + 1 < rows) begin
        chroma_store[col] = {v, u};
        queue_byte(y2i_pkg::PLANE_Y, yoff, y0, 1'b0, 1'b0);
        queue_byte(y2i_pkg::PLANE_Y, yoff + 1, y1, 1'b1, 1'b0);
      end
    end else begin
      {sv, su} = chroma_store[col];
      coff = (row / 2) * pairs + col;
      queue_byte(y2i_pkg::PLANE_Y, yoff, y0, 1'b0, 1'b0);
      queue_byte(y2i_pkg::PLANE_Y, yoff + 1, y1, 1'b0, 1'b0);
      queue_byte(y2i_pkg::PLANE_U, coff, BYTE_W'((int'(su) + int'(u)) >> 1), 1'b0, 1'b0);
      queue_byte(y2i_pkg::PLANE_V, coff, BYTE_W'((int'(sv) + int'(v)) >> 1), 1'b1,
                 end_line && (row + 2 >= rows));
    end
    if (end_frame) begin
      column_at = '0;
      row_at    = '0;
    end else if (end_line) begin
      column_at = '0;
      row_at    = row_at + 11'd1;
    end else begin
      column_at = column_at + 10'd1;
    end
  endtask

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk) begin
    planar_byte_t due;
    if (rst) begin
      line_pairs_reg = y2i_pkg::LINE_PAIRS_RST;
      frame_rows_reg = y2i_pkg::FRAME_ROWS_RST;
      column_at      = '0;
      row_at         = '0;
      planar_bytes_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (y2i_pkg::reg_index_t'(cfg_index))
          y2i_pkg::REG_LINE_PAIRS: line_pairs_reg = cfg_data[y2i_pkg::LINE_PAIRS_W-1:0];
          y2i_pkg::REG_FRAME_ROWS: frame_rows_reg = cfg_data[y2i_pkg::FRAME_ROWS_W-1:0];
          default: ;
        endcase
      end
      if (px_valid && !px_stall)
        convert_macropixel(luma_first, chroma_blue, luma_second, chroma_red);
      if (res_valid && !res_stall) begin
        if (planar_bytes_due.size() == 0) begin
          $display("%0t: stray result, expected none, actual plane %0d offset 0x%0h value 0x%0h",
                   $time, plane, offset, value);
          fault_count++;
        end else begin
          due = planar_bytes_due.pop_front();
          check_field("plane", due.plane, plane);
          check_field("offset", due.offset, offset);
          check_field("value", due.value, value);
          check_field("last_of_run", due.last, last_of_run);
          check_field("frame_done", due.done, frame_done);
        end
      end
    end
    pending <= planar_bytes_due.size();
  end

endmodule

// ===== verif/tb_yuyv422_to_yuv420_planar.sv =====
`timescale 1ns / 1ps
// Top of the yuyv422_to_yuv420_planar testbench: clock, reset, pixel and
// register stimulus, result back-pressure and verdict. Needs y2i_pkg,
// the converter RTL and y2i_plane_checker.

module tb_yuyv422_to_yuv420_planar;

  localparam int BYTE_W       = y2i_pkg::BYTE_W;
  localparam int CFG_DATA_W   = y2i_pkg::CFG_DATA_W;
  localparam int LATENCY_WAIT = 8;
  localparam int RANDOM_ITEMS = 270;
  localparam int FILL_PAIRS   = 16;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            px_valid = 1'b0;
  logic                            px_stall;
  logic [BYTE_W-1:0]               luma_first = '0;
  logic [BYTE_W-1:0]               chroma_blue = '0;
  logic [BYTE_W-1:0]               luma_second = '0;
  logic [BYTE_W-1:0]               chroma_red = '0;
  logic                            res_valid;
  logic                            res_stall = 1'b0;
  logic [y2i_pkg::PLANE_W-1:0]     plane;
  logic [y2i_pkg::OFF_W-1:0]       offset;
  logic [BYTE_W-1:0]               value;
  logic                            last_of_run;
  logic                            frame_done;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [y2i_pkg::CFG_INDEX_W-1:0] cfg_index = y2i_pkg::REG_LINE_PAIRS;
  logic [CFG_DATA_W-1:0]           cfg_data = '0;
  int unsigned                     errors;
  int unsigned                     pending;

  int unsigned burst_left = 0;
  logic [1:0]  stall_mode = 2'd0;
  int unsigned mode_left = 0;
  logic [4:0]  stall_tick = '0;

  always #10 clk = ~clk;

  yuyv422_to_yuv420_planar dut (.*);

  y2i_plane_checker plane_check (.*);

  // receiver back-pressure: the mode is redrawn when its random hold count runs out
  always @(posedge clk) begin
    stall_tick <= stall_tick + 5'd1;
    if (mode_left == 0) begin
      stall_mode <= 2'($urandom_range(0, 3));
      mode_left  <= $urandom_range(40, 400);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      2'd0:    res_stall <= 1'b0;
      2'd1:    res_stall <= ($urandom_range(0, 3) == 0);
      2'd2:    res_stall <= ($urandom_range(0, 3) != 0);
      default: res_stall <= &stall_tick[4:3];
    endcase
  end

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // line widths stay within the line-buffer entries filled at the start
  function automatic logic [CFG_DATA_W-1:0] pick_setting(input bit for_rows);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return for_rows ? 12'hFFF : 12'd6;
      2:       return for_rows ? 12'd2048 : 12'd2;
      3:       return for_rows ? 12'd3 : 12'd1;
      default: return for_rows ? 12'($urandom_range(2, 9)) : 12'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic send_pixel(input logic [BYTE_W-1:0] y0, u, y1, v);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        px_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 10);
    end
    px_valid    <= 1'b1;
    luma_first  <= y0;
    chroma_blue <= u;
    luma_second <= y1;
    chroma_red  <= v;
    @(posedge clk);
    while (px_stall) @(posedge clk);
    burst_left--;
  endtask

  task automatic write_config(input bit do_pairs, input logic [CFG_DATA_W-1:0] pairs_val,
                              input bit do_rows, input logic [CFG_DATA_W-1:0] rows_val);
    if (do_pairs) begin
      cfg_valid <= 1'b1;
      cfg_index <= y2i_pkg::REG_LINE_PAIRS;
      cfg_data  <= pairs_val;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    if (do_rows) begin
      cfg_valid <= 1'b1;
      cfg_index <= y2i_pkg::REG_FRAME_ROWS;
      cfg_data  <= rows_val;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // hold off the sender until every predicted byte has left the block
  task automatic wait_idle();
    px_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned waited;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // row 0 fills the first line-buffer entries; later lines stay narrower
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    wait_idle();
    write_config(1'b1, 12'hFFF, 1'b1, 12'hFFF);
    send_pixel(8'hAA, 8'h55, 8'hAA, 8'h55);
    send_pixel(8'h55, 8'hAA, 8'h55, 8'hAA);
    repeat (FILL_PAIRS - 4) send_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
    wait_idle();

    // shrink the line to close row 0, then widen it again for row 1
    write_config(1'b1, 12'd1, 1'b0, '0);
    send_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
    wait_idle();
    write_config(1'b1, 12'hFFF, 1'b0, '0);

    // odd row: averages against all-zero, all-one and alternating stored chroma
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    wait_idle();

    // shrink mid-row into an odd-height frame; the dropped last row follows
    write_config(1'b1, 12'd0, 1'b1, 12'd3);
    repeat (4) send_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
    wait_idle();
    write_config(1'b1, 12'd1, 1'b1, 12'd1);
    repeat (4) send_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
    wait_idle();
    write_config(1'b0, '0, 1'b1, 12'd0);
    repeat (3) send_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      write_config($urandom_range(0, 2) != 0, pick_setting(1'b0),
                   $urandom_range(0, 2) != 0, pick_setting(1'b1));
      burst = $urandom_range(8, 40);
      repeat (burst) send_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
      sent += burst;
    end

    px_valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < 50000);
    repeat (LATENCY_WAIT) @(posedge clk);
    if (pending != 0)
      $display("%0t: %0d predicted bytes never transferred", $time, pending);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
